>>> sv/key_debounce_autorepeat_macros.svh
// Assertion macros shared by the key debounce design.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_MACROS_SVH

`ifndef SYNTHESIS
`define KDA_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("Key debounce assertion failed in the same cycle.");
`define KDA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("Key debounce assertion failed in the next cycle.");
`else
`define KDA_ASSERT_SAME(lbl, a, c)
`define KDA_ASSERT_NEXT(lbl, a, c)
`endif

`endif

>>> sv/kda_pkg.sv
`timescale 1ns / 1ps

package kda_pkg;

  localparam int unsigned CountWidth = 9;
  localparam int unsigned PeriodWidth = 8;

  localparam logic [CountWidth-1:0] CHECK_INTERVAL = 9'd50;
  localparam logic [CountWidth-1:0] HOLD_WAIT = 9'd350;
  localparam logic [CountWidth-1:0] COUNT_MAX = 9'd511;
  localparam logic [PeriodWidth-1:0] REPEAT_PERIOD_RESET = 8'd100;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CHECK1 = 4'd1,
    PH_CHECK2 = 4'd2,
    PH_CHECK3 = 4'd3,
    PH_CHECK4 = 4'd4,
    PH_CHECK5 = 4'd5,
    PH_CHECK6 = 4'd6,
    PH_WAIT   = 4'd7,
    PH_REPEAT = 4'd8
  } phase_t;

endpackage

>>> sv/kda_ifs.sv
`timescale 1ns / 1ps

interface kda_key_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink (input valid, input pressed, output ready);
endinterface

interface kda_click_if;
  logic valid;
  logic ready;
  logic short_press;
  logic held_repeat;

  modport source (output valid, output short_press, output held_repeat, input ready);
  modport sink (input valid, input short_press, input held_repeat, output ready);
endinterface

>>> sv/key_debounce_autorepeat.sv
`timescale 1ns / 1ps
// Latency: the result of a tick item is registered and shown in the cycle after it is accepted.
// Throughput: one tick item per cycle while no result waits untaken; phase and counter update on each accepted item.
// A waiting result holds off the next item unless the receiver takes it in the same cycle.
// Synchronous reset returns to idle with a zero tick count and a repeat period of 100.
`include "key_debounce_autorepeat_macros.svh"

module key_debounce_autorepeat (
  input  logic              clk,
  input  logic              rst,
  kda_key_if.sink           key_in,
  kda_click_if.source       click_out,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import kda_pkg::*;

  logic [PeriodWidth-1:0] repeat_period;
  phase_t                 phase;
  phase_t                 phase_next;
  logic [CountWidth-1:0]  tick_count;
  logic [CountWidth-1:0]  tick_count_next;
  logic                   out_valid;
  logic                   out_single;
  logic                   out_repeat;
  logic                   single_next;
  logic                   repeat_next;
  logic                   accept;
  logic [PeriodWidth-1:0] period;

  assign key_in.ready = !out_valid || click_out.ready;
  assign accept = key_in.valid && key_in.ready;
  assign period = (repeat_period == '0) ? PeriodWidth'(1) : repeat_period;

  assign click_out.valid = out_valid;
  assign click_out.short_press = out_single;
  assign click_out.held_repeat = out_repeat;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_period <= REPEAT_PERIOD_RESET;
    end else if (cfg_we) begin
      repeat_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      tick_count <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (click_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_single <= single_next;
      out_repeat <= repeat_next;
    end
  end

  always_comb begin
    phase_t                ph;
    logic [CountWidth-1:0] cnt;
    ph = (phase > PH_REPEAT) ? PH_IDLE : phase;
    cnt = tick_count;
    single_next = 1'b0;
    repeat_next = 1'b0;
    if (key_in.pressed && ph == PH_IDLE) begin
      ph = PH_CHECK1;
      cnt = '0;
    end
    case (ph)
      PH_CHECK1, PH_CHECK2, PH_CHECK3, PH_CHECK4, PH_CHECK5, PH_CHECK6: begin
        if (cnt == CHECK_INTERVAL) begin
          cnt = '0;
          if (key_in.pressed) begin
            ph = phase_t'(ph + 4'd1);
          end else begin
            single_next = 1'b1;
            ph = PH_IDLE;
          end
        end
      end
      PH_WAIT: begin
        if (cnt == HOLD_WAIT) begin
          cnt = '0;
          if (key_in.pressed) begin
            repeat_next = 1'b1;
            ph = PH_REPEAT;
          end else begin
            ph = PH_IDLE;
          end
        end
      end
      PH_REPEAT: begin
        if (cnt == CountWidth'(period)) begin
          cnt = '0;
          if (key_in.pressed) begin
            repeat_next = 1'b1;
          end else begin
            ph = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
    if (cnt != COUNT_MAX) begin
      cnt = cnt + CountWidth'(1);
    end
    phase_next = ph;
    tick_count_next = cnt;
  end

  `KDA_ASSERT_SAME(a_one_click_kind, out_valid, !(out_single && out_repeat))
  `KDA_ASSERT_NEXT(a_count_moves, accept, tick_count != '0)
  `KDA_ASSERT_NEXT(a_repeat_enters_repeat, accept && repeat_next, phase == PH_REPEAT)
  `KDA_ASSERT_NEXT(a_single_to_idle, accept && single_next, phase == PH_IDLE)
  `KDA_ASSERT_NEXT(a_hold_when_idle, !accept, $stable(tick_count) && $stable(phase))

endmodule
